@@ src/rgci_pkg.sv @@
package rgci_pkg;

    localparam int OFFSET_W   = 6;
    localparam int GSIZE_W    = 8;
    localparam int RADIUS_W   = 6;
    localparam int D2_W       = 13;
    localparam int GG_W       = 2 * GSIZE_W;
    localparam int RADICAND_W = 30;
    localparam int ROOT_W     = RADICAND_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int STEP_W     = 4;
    localparam int SETUP_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int MUL_STEPS  = GG_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = ROOT_W;

    localparam logic [OFFSET_W-1:0]  MAX_OFFSET   = 6'd63;
    localparam logic [GSIZE_W-1:0]   GSIZE_RESET  = 8'd16;
    localparam logic [RADIUS_W-1:0]  RADIUS_RESET = 6'd32;

    localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLAST_RADIUS  = 2'd1;

    typedef struct packed {
        logic [OFFSET_W-1:0] column_offset;
        logic [OFFSET_W-1:0] column_height;
    } t_in_beat;

    typedef struct packed {
        logic [OFFSET_W-1:0] row_offset;
        logic [GSIZE_W-1:0]  band_index;
        logic                last_row;
    } t_out_beat;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_beat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_band_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_START,
        S_WAIT,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_SQRT,
        U_DIV,
        U_DONE
    } t_unit_state;

    function automatic logic [OFFSET_W-1:0] sat_offset(input logic [OFFSET_W-1:0] v);
        sat_offset = (v > MAX_OFFSET) ? MAX_OFFSET : v;
    endfunction

endpackage

@@ src/rgci_stream_if.sv @@
interface rgci_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/radial_gradient_column_index_top.sv @@
// Radial gradient column indexer. Each input beat names one column of a disc by its
// horizontal offset dx and its height dy; the block then sends dy+1 output beats, one
// for each row y = 0..dy, carrying y, the band index
// min(isqrt((dx^2+y^2)*gsize^2) / radius, gsize) and a flag on the final row. With
// a zero radius the band is gsize. A column is first accepted and set up (gsize^2 and
// dx^2 by serial shift-add, one bit per cycle), then each row is worked while the
// output is free: the serial product, the square root (one root bit per cycle) and
// the restoring division by the radius, plus handoff. One column is worked at a time;
// the last row sits in the output register while the next column is accepted.
// Configuration (index 0 gradient_size, index 1 blast_radius, others ignored) is
// always ready and must only be written while the block is idle.
module radial_gradient_column_index_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgci_stream_if.sink   i_in,
    rgci_stream_if.source o_out,
    rgci_stream_if.sink   i_cfg
);
    import rgci_pkg::*;

    // control state
    t_state               r_state, n_state;
    logic [SETUP_W-1:0]   r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [GSIZE_W-1:0]   r_gsize;
    logic [RADIUS_W-1:0]  r_radius;

    // column datapath
    logic [OFFSET_W-1:0]  r_dx, n_dx;
    logic [OFFSET_W-1:0]  r_height, n_height;
    logic [OFFSET_W-1:0]  r_row, n_row;
    logic [GSIZE_W-1:0]   r_gbits, n_gbits;
    logic [GSIZE_W-1:0]   r_dxbits, n_dxbits;
    logic [GG_W-1:0]      r_gg, n_gg;
    logic [D2_W-1:0]      r_d2, n_d2;
    t_out_beat            r_out, n_out;

    logic                 w_accept;
    logic                 w_start;
    logic                 w_slot_free;
    logic                 w_last;
    t_band_status         w_status;
    logic [GSIZE_W-1:0]   w_band;
    t_cfg_beat            w_cfg;

    assign w_cfg       = i_cfg.data;
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_last      = (r_row == r_height);
    assign w_start     = (r_state == S_START);

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gsize  <= GSIZE_RESET;
            r_radius <= RADIUS_RESET;
        end else if (i_cfg.valid) begin
            case (w_cfg.index)
                REG_GRADIENT_SIZE: r_gsize  <= w_cfg.data;
                REG_BLAST_RADIUS:  r_radius <= w_cfg.data[RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx     <= n_dx;
        r_height <= n_height;
        r_row    <= n_row;
        r_gbits  <= n_gbits;
        r_dxbits <= n_dxbits;
        r_gg     <= n_gg;
        r_d2     <= n_d2;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_dx        = r_dx;
        n_height    = r_height;
        n_row       = r_row;
        n_gbits     = r_gbits;
        n_dxbits    = r_dxbits;
        n_gg        = r_gg;
        n_d2        = r_d2;
        n_out       = r_out;

        // output beat taken, slot empties unless refilled below
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_dx     = sat_offset(i_in.data.column_offset);
                    n_height = sat_offset(i_in.data.column_height);
                    n_dxbits = GSIZE_W'(sat_offset(i_in.data.column_offset));
                    n_gbits  = r_gsize;
                    n_row    = '0;
                    n_gg     = '0;
                    n_d2     = '0;
                    n_cnt    = '0;
                    n_state  = S_SETUP;
                end
            end
            S_SETUP: begin
                // gsize^2 and dx^2 side by side, one multiplier bit per cycle
                n_gg     = {r_gg[GG_W-2:0], 1'b0}
                         + (r_gbits[GSIZE_W-1] ? GG_W'(r_gsize) : '0);
                n_d2     = {r_d2[D2_W-2:0], 1'b0}
                         + (r_dxbits[GSIZE_W-1] ? D2_W'(r_dx) : '0);
                n_gbits  = {r_gbits[GSIZE_W-2:0], 1'b0};
                n_dxbits = {r_dxbits[GSIZE_W-2:0], 1'b0};
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == SETUP_W'(GSIZE_W - 1)) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_status.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid      = 1'b1;
                    n_out.row_offset = r_row;
                    n_out.band_index = w_band;
                    n_out.last_row   = w_last;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // next row: d2 grows by 2y+1
                        n_d2    = r_d2 + D2_W'({r_row, 1'b1});
                        n_row   = r_row + 1'b1;
                        n_state = S_START;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    rgci_band_unit u_band (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_d2     (r_d2),
        .i_gg     (r_gg),
        .i_gsize  (r_gsize),
        .i_radius (r_radius),
        .o_status (w_status),
        .o_band   (w_band)
    );

    // a row is only launched into an idle band unit
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !w_status.busy)
        else $error("band unit started while busy");

    // while waiting, the band unit must be working on the row
    a_wait_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> w_status.busy)
        else $error("waiting on an idle band unit");

    // results only arrive when the sequencer waits for them
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.done |-> (r_state == S_WAIT))
        else $error("band result outside wait");

    // band index never passes the band count
    a_band_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.done |-> (w_band <= r_gsize))
        else $error("band index above gradient size");

endmodule

@@ src/rgci_band_unit.sv @@
module rgci_band_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rgci_pkg::D2_W-1:0]     i_d2,
    input  logic [rgci_pkg::GG_W-1:0]     i_gg,
    input  logic [rgci_pkg::GSIZE_W-1:0]  i_gsize,
    input  logic [rgci_pkg::RADIUS_W-1:0] i_radius,
    output rgci_pkg::t_band_status        o_status,
    output logic [rgci_pkg::GSIZE_W-1:0]  o_band
);
    import rgci_pkg::*;

    t_unit_state           r_state, n_state;
    logic [STEP_W-1:0]     r_cnt, n_cnt;
    logic [D2_W-1:0]       r_d2, n_d2;
    logic [GG_W-1:0]       r_mplier, n_mplier;
    logic [RADICAND_W-1:0] r_rad, n_rad;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [ROOT_W-1:0]     r_root, n_root;
    logic [RADIUS_W-1:0]   r_drem, n_drem;

    logic [REM_W-1:0]      w_rem_sh;
    logic [REM_W-1:0]      w_trial;
    logic [RADIUS_W:0]     w_part;
    logic                  w_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d2     <= n_d2;
        r_mplier <= n_mplier;
        r_rad    <= n_rad;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_drem   <= n_drem;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_d2     = r_d2;
        n_mplier = r_mplier;
        n_rad    = r_rad;
        n_rem    = r_rem;
        n_root   = r_root;
        n_drem   = r_drem;
        w_rem_sh = {r_rem[REM_W-3:0], r_rad[RADICAND_W-1 -: 2]};
        w_trial  = {r_root, 2'b01};
        w_part   = {r_drem, r_root[ROOT_W-1]};
        w_ge     = (w_part >= {1'b0, i_radius});
        case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    n_d2     = i_d2;
                    n_mplier = i_gg;
                    n_rad    = '0;
                    n_cnt    = '0;
                    n_state  = U_MUL;
                end
            end
            U_MUL: begin
                // shift-add, one multiplier bit per cycle, msb first
                n_rad    = {r_rad[RADICAND_W-2:0], 1'b0}
                         + (r_mplier[GG_W-1] ? RADICAND_W'(r_d2) : '0);
                n_mplier = {r_mplier[GG_W-2:0], 1'b0};
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(MUL_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_root  = '0;
                    n_state = U_SQRT;
                end
            end
            U_SQRT: begin
                // one root bit per cycle, two radicand bits consumed
                if (w_rem_sh >= w_trial) begin
                    n_rem  = w_rem_sh - w_trial;
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = w_rem_sh;
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                n_rad = {r_rad[RADICAND_W-3:0], 2'b00};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_drem  = '0;
                    n_state = U_DIV;
                end
            end
            U_DIV: begin
                // restoring division, quotient bits replace root bits
                if (w_ge) begin
                    n_drem = RADIUS_W'(w_part - {1'b0, i_radius});
                end else begin
                    n_drem = RADIUS_W'(w_part);
                end
                n_root = {r_root[ROOT_W-2:0], w_ge};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = U_DONE;
                end
            end
            U_DONE: begin
                n_state = U_IDLE;
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    // zero radius or a quotient above the band count saturates at the band count
    assign o_band = ((i_radius == '0) || (r_root > ROOT_W'(i_gsize))) ? i_gsize
                                                                        : GSIZE_W'(r_root);
    assign o_status.busy = (r_state != U_IDLE);
    assign o_status.done = (r_state == U_DONE);

endmodule
